// File: hdl/tblv_pkg.sv
// ----------------------------------------------------------------------------
// tblv_pkg
// Shared types and constants of the tape block load and verify unit.
// ----------------------------------------------------------------------------
package tblv_pkg;

    localparam int ADDR_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_CNT_W  = 2;

    typedef enum logic [1:0] {
        REG_EXPECTED_FLAG = 2'd0,
        REG_LOAD_MODE     = 2'd1,
        REG_BYTE_COUNT    = 2'd2,
        REG_START_ADDRESS = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_DATA = 2'd1,
        PH_SUM  = 2'd2,
        PH_SKIP = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FLAG   = 3'd1,
        ST_VERIFY = 3'd2,
        ST_SHORT  = 3'd3,
        ST_SUM    = 3'd4
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0]  expected_flag;
        logic               load_mode;
        logic [COUNT_W-1:0] byte_count;
        logic [ADDR_W-1:0]  start_address;
    } t_cfg;

    typedef struct packed {
        logic               is_data;
        logic               is_finish;
        logic               write_enable;
        logic [ADDR_W-1:0]  access_address;
        logic [BYTE_W-1:0]  write_data;
        t_status            status;
        logic [BYTE_W-1:0]  parity;
        logic [COUNT_W-1:0] remaining;
        logic [ADDR_W-1:0]  next_address;
    } t_rec;

endpackage

// File: hdl/tblv_front.sv
// ----------------------------------------------------------------------------
// tblv_front
// Accepts tape bytes, tracks the block phase, parity, count and address, and
// classifies each byte into a result record for the queue.
// ----------------------------------------------------------------------------
module tblv_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tblv_pkg::t_cfg                i_cfg,
    input  logic                          i_take,
    input  logic [tblv_pkg::BYTE_W-1:0]   i_tape_byte,
    input  logic [tblv_pkg::BYTE_W-1:0]   i_mem_byte,
    input  logic                          i_last_byte,
    output tblv_pkg::t_rec                o_rec
);

    tblv_pkg::t_phase                   r_phase, n_phase;
    logic [tblv_pkg::BYTE_W-1:0]        r_parity, n_parity;
    logic [tblv_pkg::COUNT_W-1:0]       r_remain, n_remain;
    logic [tblv_pkg::ADDR_W-1:0]        r_dest, n_dest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= tblv_pkg::PH_FLAG;
            r_parity <= '0;
            r_remain <= '0;
            r_dest   <= '0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_parity <= n_parity;
            r_remain <= n_remain;
            r_dest   <= n_dest;
        end
    end

    always_comb begin
        logic [tblv_pkg::BYTE_W-1:0] par_x;
        par_x    = r_parity ^ i_tape_byte;
        n_phase  = r_phase;
        n_parity = r_parity;
        n_remain = r_remain;
        n_dest   = r_dest;
        o_rec    = '0;
        o_rec.status = tblv_pkg::ST_OK;
        case (r_phase)
            tblv_pkg::PH_FLAG: begin
                n_remain = i_cfg.byte_count;
                n_dest   = i_cfg.start_address;
                if (i_tape_byte != i_cfg.expected_flag) begin
                    n_parity        = '0;
                    o_rec.is_finish = 1'b1;
                    o_rec.status    = tblv_pkg::ST_FLAG;
                    n_phase = i_last_byte ? tblv_pkg::PH_FLAG : tblv_pkg::PH_SKIP;
                end else begin
                    n_parity = i_tape_byte;
                    if (i_last_byte) begin
                        o_rec.is_finish = 1'b1;
                        o_rec.status    = tblv_pkg::ST_SHORT;
                        n_phase         = tblv_pkg::PH_FLAG;
                    end else if (i_cfg.byte_count == '0) begin
                        n_phase = tblv_pkg::PH_SUM;
                    end else begin
                        n_phase = tblv_pkg::PH_DATA;
                    end
                end
            end
            tblv_pkg::PH_DATA: begin
                n_parity             = par_x;
                o_rec.is_data        = 1'b1;
                o_rec.access_address = r_dest;
                o_rec.write_data     = i_tape_byte;
                o_rec.write_enable   = i_cfg.load_mode;
                if (!i_cfg.load_mode && (i_mem_byte != i_tape_byte)) begin
                    o_rec.is_finish = 1'b1;
                    o_rec.status    = tblv_pkg::ST_VERIFY;
                    n_phase = i_last_byte ? tblv_pkg::PH_FLAG : tblv_pkg::PH_SKIP;
                end else begin
                    n_remain = r_remain - 1'b1;
                    n_dest   = r_dest + 1'b1;
                    if (i_last_byte) begin
                        o_rec.is_finish = 1'b1;
                        o_rec.status    = tblv_pkg::ST_SHORT;
                        n_phase         = tblv_pkg::PH_FLAG;
                    end else if (n_remain == '0) begin
                        n_phase = tblv_pkg::PH_SUM;
                    end
                end
            end
            tblv_pkg::PH_SUM: begin
                n_parity        = par_x;
                o_rec.is_finish = 1'b1;
                o_rec.status    = (par_x == '0) ? tblv_pkg::ST_OK : tblv_pkg::ST_SUM;
                n_phase = i_last_byte ? tblv_pkg::PH_FLAG : tblv_pkg::PH_SKIP;
            end
            default: begin
                if (i_last_byte) begin
                    n_phase = tblv_pkg::PH_FLAG;
                end
            end
        endcase
        o_rec.parity       = n_parity;
        o_rec.remaining    = n_remain;
        o_rec.next_address = n_dest;
    end

endmodule

// File: hdl/tblv_queue.sv
// ----------------------------------------------------------------------------
// tblv_queue
// Two-entry queue of result records between the front and the back.
// ----------------------------------------------------------------------------
module tblv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tblv_pkg::t_rec  i_rec,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tblv_pkg::t_rec  o_rec
);

    tblv_pkg::t_rec                 r_mem [tblv_pkg::Q_DEPTH];
    logic [tblv_pkg::Q_PTR_W-1:0]   r_wr_ptr;
    logic [tblv_pkg::Q_PTR_W-1:0]   r_rd_ptr;
    logic [tblv_pkg::Q_CNT_W-1:0]   r_count;
    logic                           do_pop;

    assign o_full  = (r_count == tblv_pkg::Q_CNT_W'(tblv_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/tblv_back.sv
// ----------------------------------------------------------------------------
// tblv_back
// Takes records from the queue and presents them in the output register,
// clearing the fields that do not apply to each result.
// ----------------------------------------------------------------------------
module tblv_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  tblv_pkg::t_rec                i_q_rec,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_write_enable,
    output logic [tblv_pkg::ADDR_W-1:0]   o_access_address,
    output logic [tblv_pkg::BYTE_W-1:0]   o_write_data,
    output logic                          o_finished,
    output logic [2:0]                    o_status,
    output logic [tblv_pkg::BYTE_W-1:0]   o_parity_out,
    output logic [tblv_pkg::COUNT_W-1:0]  o_bytes_remaining,
    output logic [tblv_pkg::ADDR_W-1:0]   o_next_address
);

    logic               r_valid;
    tblv_pkg::t_rec     r_out;
    tblv_pkg::t_rec     n_out;
    logic               load;

    assign load    = !r_valid || !i_stall;
    assign o_q_pop = load && i_q_valid;

    always_comb begin
        n_out = '0;
        n_out.status = tblv_pkg::ST_OK;
        if (i_q_rec.is_data) begin
            n_out.is_data        = 1'b1;
            n_out.access_address = i_q_rec.access_address;
            if (i_q_rec.write_enable) begin
                n_out.write_enable = 1'b1;
                n_out.write_data   = i_q_rec.write_data;
            end
        end
        if (i_q_rec.is_finish) begin
            n_out.is_finish    = 1'b1;
            n_out.status       = i_q_rec.status;
            n_out.parity       = i_q_rec.parity;
            n_out.remaining    = i_q_rec.remaining;
            n_out.next_address = i_q_rec.next_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

    assign o_valid           = r_valid;
    assign o_write_enable    = r_out.write_enable;
    assign o_access_address  = r_out.access_address;
    assign o_write_data      = r_out.write_data;
    assign o_finished        = r_out.is_finish;
    assign o_status          = r_out.status;
    assign o_parity_out      = r_out.parity;
    assign o_bytes_remaining = r_out.remaining;
    assign o_next_address    = r_out.next_address;

endmodule

// File: hdl/tape_block_load_verify.sv
// ----------------------------------------------------------------------------
// tape_block_load_verify
// Loads or verifies one tape block byte by byte with an XOR checksum.
// ----------------------------------------------------------------------------
// Every accepted tape byte gives exactly one result, and a new byte can be
// accepted in every cycle while the input is not stalled. Each result takes
// this path: the front computes it in the accept cycle, it passes a two-entry
// queue, and the output register presents it. When the output is stalled the
// queue and the output register hold three results before the input stalls.
// Configuration registers must be written only while no tape byte is in
// flight; they are sampled as each byte is accepted.
module tape_block_load_verify (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tblv_pkg::PADDR_W-1:0]  paddr,
    input  logic [tblv_pkg::PDATA_W-1:0]  pwdata,
    output logic [tblv_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [tblv_pkg::BYTE_W-1:0]   i_tape_byte,
    input  logic [tblv_pkg::BYTE_W-1:0]   i_mem_byte,
    input  logic                          i_last_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_write_enable,
    output logic [tblv_pkg::ADDR_W-1:0]   o_access_address,
    output logic [tblv_pkg::BYTE_W-1:0]   o_write_data,
    output logic                          o_finished,
    output logic [2:0]                    o_status,
    output logic [tblv_pkg::BYTE_W-1:0]   o_parity_out,
    output logic [tblv_pkg::COUNT_W-1:0]  o_bytes_remaining,
    output logic [tblv_pkg::ADDR_W-1:0]   o_next_address
);

    tblv_pkg::t_cfg     r_cfg;
    tblv_pkg::t_reg_idx reg_idx;
    tblv_pkg::t_rec     front_rec;
    tblv_pkg::t_rec     q_rec;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic               take;

    assign pready  = 1'b1;
    assign reg_idx = tblv_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_flag <= '0;
            r_cfg.load_mode     <= 1'b1;
            r_cfg.byte_count    <= '0;
            r_cfg.start_address <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                tblv_pkg::REG_EXPECTED_FLAG: r_cfg.expected_flag <= pwdata[7:0];
                tblv_pkg::REG_LOAD_MODE:     r_cfg.load_mode     <= pwdata[0];
                tblv_pkg::REG_BYTE_COUNT:    r_cfg.byte_count    <= pwdata[15:0];
                tblv_pkg::REG_START_ADDRESS: r_cfg.start_address <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            tblv_pkg::REG_EXPECTED_FLAG: prdata[7:0]  = r_cfg.expected_flag;
            tblv_pkg::REG_LOAD_MODE:     prdata[0]    = r_cfg.load_mode;
            tblv_pkg::REG_BYTE_COUNT:    prdata[15:0] = r_cfg.byte_count;
            tblv_pkg::REG_START_ADDRESS: prdata[15:0] = r_cfg.start_address;
            default:                     prdata       = '0;
        endcase
    end

    assign o_stall = q_full;
    assign take    = i_valid && !q_full;

    tblv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_take      (take),
        .i_tape_byte (i_tape_byte),
        .i_mem_byte  (i_mem_byte),
        .i_last_byte (i_last_byte),
        .o_rec       (front_rec)
    );

    tblv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    tblv_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_rec           (q_rec),
        .o_q_pop           (q_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_write_enable    (o_write_enable),
        .o_access_address  (o_access_address),
        .o_write_data      (o_write_data),
        .o_finished        (o_finished),
        .o_status          (o_status),
        .o_parity_out      (o_parity_out),
        .o_bytes_remaining (o_bytes_remaining),
        .o_next_address    (o_next_address)
    );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tape block load and verify unit. Tape bytes
// go in as requests with random gaps and output stalls. A predictor follows
// the flag, data and checksum phases, and every result is checked field by
// field against its expected value. Registers are set over the APB port
// only after all results are in.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                         write_enable;
        logic [tblv_pkg::ADDR_W-1:0]  access_address;
        logic [tblv_pkg::BYTE_W-1:0]  write_data;
        logic                         finished;
        tblv_pkg::t_status            status;
        logic [tblv_pkg::BYTE_W-1:0]  parity_out;
        logic [tblv_pkg::COUNT_W-1:0] bytes_remaining;
        logic [tblv_pkg::ADDR_W-1:0]  next_address;
    } t_tape_result;

    typedef enum {
        BLK_GOOD,
        BLK_BAD_FLAG,
        BLK_VERIFY_ERR,
        BLK_SHORT,
        BLK_BAD_SUM,
        BLK_TRAILING
    } t_block_kind;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [tblv_pkg::PADDR_W-1:0]  paddr = '0;
    logic [tblv_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [tblv_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [tblv_pkg::BYTE_W-1:0]   i_tape_byte = '0;
    logic [tblv_pkg::BYTE_W-1:0]   i_mem_byte = '0;
    logic                          i_last_byte = 1'b0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic                          o_write_enable;
    logic [tblv_pkg::ADDR_W-1:0]   o_access_address;
    logic [tblv_pkg::BYTE_W-1:0]   o_write_data;
    logic                          o_finished;
    logic [2:0]                    o_status;
    logic [tblv_pkg::BYTE_W-1:0]   o_parity_out;
    logic [tblv_pkg::COUNT_W-1:0]  o_bytes_remaining;
    logic [tblv_pkg::ADDR_W-1:0]   o_next_address;

    logic [tblv_pkg::BYTE_W-1:0]   cfg_flag = 8'h00;
    logic                          cfg_load = 1'b1;
    logic [tblv_pkg::COUNT_W-1:0]  cfg_count = '0;
    logic [tblv_pkg::ADDR_W-1:0]   cfg_start = '0;

    tblv_pkg::t_phase              ld_phase = tblv_pkg::PH_FLAG;
    logic [tblv_pkg::BYTE_W-1:0]   ld_parity = '0;
    logic [tblv_pkg::COUNT_W-1:0]  ld_remaining = '0;
    logic [tblv_pkg::ADDR_W-1:0]   ld_dest = '0;

    t_tape_result        pending_results[$];
    int                  n_bytes_sent = 0;
    int                  n_results_seen = 0;
    int                  n_errors = 0;
    bit                  steady_flow = 1'b0;

    tape_block_load_verify u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_tape_byte       (i_tape_byte),
        .i_mem_byte        (i_mem_byte),
        .i_last_byte       (i_last_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_write_enable    (o_write_enable),
        .o_access_address  (o_access_address),
        .o_write_data      (o_write_data),
        .o_finished        (o_finished),
        .o_status          (o_status),
        .o_parity_out      (o_parity_out),
        .o_bytes_remaining (o_bytes_remaining),
        .o_next_address    (o_next_address)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_tape_result predict_tape_byte(
        input logic [tblv_pkg::BYTE_W-1:0] b,
        input logic [tblv_pkg::BYTE_W-1:0] m,
        input logic                        is_last);
        t_tape_result       r;
        logic               done;
        logic               done_last;
        tblv_pkg::t_status  st;
        r = '0;
        done = 1'b0;
        done_last = 1'b0;
        st = tblv_pkg::ST_OK;
        case (ld_phase)
            tblv_pkg::PH_FLAG: begin
                ld_remaining = cfg_count;
                ld_dest = cfg_start;
                if (b != cfg_flag) begin
                    ld_parity = '0;
                    done = 1'b1;
                    st = tblv_pkg::ST_FLAG;
                    done_last = is_last;
                end else begin
                    ld_parity = b;
                    if (is_last) begin
                        done = 1'b1;
                        st = tblv_pkg::ST_SHORT;
                        done_last = 1'b1;
                    end else begin
                        ld_phase = (ld_remaining == 0) ? tblv_pkg::PH_SUM : tblv_pkg::PH_DATA;
                    end
                end
            end
            tblv_pkg::PH_DATA: begin
                ld_parity = ld_parity ^ b;
                r.access_address = ld_dest;
                if (cfg_load) begin
                    r.write_enable = 1'b1;
                    r.write_data = b;
                end
                if (!cfg_load && m != b) begin
                    done = 1'b1;
                    st = tblv_pkg::ST_VERIFY;
                    done_last = is_last;
                end else begin
                    ld_remaining = ld_remaining - 16'd1;
                    ld_dest = ld_dest + 16'd1;
                    if (is_last) begin
                        done = 1'b1;
                        st = tblv_pkg::ST_SHORT;
                        done_last = 1'b1;
                    end else if (ld_remaining == 0) begin
                        ld_phase = tblv_pkg::PH_SUM;
                    end
                end
            end
            tblv_pkg::PH_SUM: begin
                ld_parity = ld_parity ^ b;
                done = 1'b1;
                st = (ld_parity == 0) ? tblv_pkg::ST_OK : tblv_pkg::ST_SUM;
                done_last = is_last;
            end
            default: begin
                if (is_last) begin
                    ld_phase = tblv_pkg::PH_FLAG;
                end
            end
        endcase
        if (done) begin
            r.finished = 1'b1;
            r.status = st;
            r.parity_out = ld_parity;
            r.bytes_remaining = ld_remaining;
            r.next_address = ld_dest;
            ld_phase = done_last ? tblv_pkg::PH_FLAG : tblv_pkg::PH_SKIP;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        i_stall <= !steady_flow && ($urandom_range(0, 99) < 32);
    end

    always @(posedge i_clk) begin : result_monitor
        t_tape_result got;
        t_tape_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.write_enable = o_write_enable;
                got.access_address = o_access_address;
                got.write_data = o_write_data;
                got.finished = o_finished;
                got.status = tblv_pkg::t_status'(o_status);
                got.parity_out = o_parity_out;
                got.bytes_remaining = o_bytes_remaining;
                got.next_address = o_next_address;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("unexpected result: we=%0b addr=%h data=%h fin=%0b st=%0d",
                                 got.write_enable, got.access_address, got.write_data,
                                 got.finished, got.status);
                    end
                end else begin
                    want = pending_results.pop_front();
                    n_results_seen++;
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display("result %0d mismatch", n_results_seen);
                            $display({"  expected we=%0b addr=%h data=%h fin=%0b",
                                      " st=%0d par=%h rem=%h next=%h"},
                                     want.write_enable, want.access_address, want.write_data,
                                     want.finished, want.status, want.parity_out,
                                     want.bytes_remaining, want.next_address);
                            $display({"  actual   we=%0b addr=%h data=%h fin=%0b",
                                      " st=%0d par=%h rem=%h next=%h"},
                                     got.write_enable, got.access_address, got.write_data,
                                     got.finished, got.status, got.parity_out,
                                     got.bytes_remaining, got.next_address);
                        end
                    end
                end
            end
            if (i_valid && !o_stall) begin
                pending_results.insert(pending_results.size(),
                                       predict_tape_byte(i_tape_byte, i_mem_byte,
                                                         i_last_byte));
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_byte(input logic [tblv_pkg::BYTE_W-1:0] tape,
                             input logic [tblv_pkg::BYTE_W-1:0] mem,
                             input logic is_last);
        while (!steady_flow && $urandom_range(0, 99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_tape_byte <= tape;
        i_mem_byte <= mem;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        n_bytes_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (n_results_seen < n_bytes_sent) begin
            @(posedge i_clk);
        end
    endtask

    task automatic program_reg(input tblv_pkg::t_reg_idx idx,
                               input logic [tblv_pkg::PDATA_W-1:0] value);
        drain_results();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= tblv_pkg::PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            tblv_pkg::REG_EXPECTED_FLAG: cfg_flag = value[tblv_pkg::BYTE_W-1:0];
            tblv_pkg::REG_LOAD_MODE:     cfg_load = value[0];
            tblv_pkg::REG_BYTE_COUNT:    cfg_count = value[tblv_pkg::COUNT_W-1:0];
            tblv_pkg::REG_START_ADDRESS: cfg_start = value[tblv_pkg::ADDR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_tail(input int n);
        for (int j = 0; j < n; j++) begin
            send_byte(8'($urandom), 8'($urandom), j == n - 1);
        end
    endtask

    task automatic send_block(input t_block_kind kind);
        logic [tblv_pkg::BYTE_W-1:0] parity;
        logic [tblv_pkg::BYTE_W-1:0] data;
        logic [tblv_pkg::BYTE_W-1:0] mem;
        logic              is_last;
        logic              stopped;
        int                err_at;
        int                n_data;
        n_data = int'(cfg_count);
        err_at = (n_data > 0) ? $urandom_range(0, n_data - 1) : 0;
        if (kind == BLK_VERIFY_ERR && (cfg_load || n_data == 0)) begin
            kind = BLK_GOOD;
        end
        if (kind == BLK_BAD_FLAG) begin
            is_last = 1'($urandom_range(0, 1));
            send_byte(cfg_flag ^ 8'($urandom_range(1, 255)), 8'($urandom), is_last);
            if (!is_last) begin
                send_tail($urandom_range(1, 3));
            end
        end else if (kind == BLK_SHORT && (n_data == 0 || $urandom_range(0, 3) == 0)) begin
            send_byte(cfg_flag, 8'($urandom), 1'b1);
        end else begin
            parity = cfg_flag;
            stopped = 1'b0;
            send_byte(cfg_flag, 8'($urandom), 1'b0);
            for (int i = 0; i < n_data && !stopped; i++) begin
                data = 8'($urandom);
                mem = cfg_load ? 8'($urandom) : data;
                if (kind == BLK_VERIFY_ERR && i == err_at) begin
                    is_last = 1'($urandom_range(0, 1));
                    send_byte(data, data ^ 8'($urandom_range(1, 255)), is_last);
                    if (!is_last) begin
                        send_tail($urandom_range(1, 3));
                    end
                    stopped = 1'b1;
                end else begin
                    is_last = (kind == BLK_SHORT && i == err_at);
                    send_byte(data, mem, is_last);
                    parity = parity ^ data;
                    stopped = is_last;
                end
            end
            if (!stopped) begin
                if (kind == BLK_BAD_SUM) begin
                    parity = parity ^ 8'($urandom_range(1, 255));
                end
                send_byte(parity, 8'($urandom), kind != BLK_TRAILING);
                if (kind == BLK_TRAILING) begin
                    send_tail($urandom_range(1, 3));
                end
            end
        end
    endtask

    task automatic shuffle_config();
        int pick;
        pick = $urandom_range(0, 9);
        program_reg(tblv_pkg::REG_EXPECTED_FLAG, pick == 0 ? 32'h00 : pick == 1 ? 32'hFF :
                                                 $urandom_range(0, 255));
        program_reg(tblv_pkg::REG_LOAD_MODE, $urandom_range(0, 1));
        pick = $urandom_range(0, 19);
        program_reg(tblv_pkg::REG_BYTE_COUNT, pick == 0 ? $urandom_range(64, 200) :
                                              pick < 8 ? $urandom_range(7, 24) :
                                              $urandom_range(0, 6));
        pick = $urandom_range(0, 3);
        program_reg(tblv_pkg::REG_START_ADDRESS,
                    pick == 0 ? $urandom_range(16'hFFF0, 16'hFFFF) :
                    $urandom_range(0, 16'hFFFF));
    endtask

    task automatic test_zero_length();
        send_byte(8'h00, 8'hFF, 1'b0);
        send_byte(8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_load_wrap();
        program_reg(tblv_pkg::REG_EXPECTED_FLAG, 32'hFF);
        program_reg(tblv_pkg::REG_BYTE_COUNT, 32'd2);
        program_reg(tblv_pkg::REG_START_ADDRESS, 32'hFFFF);
        send_byte(8'hFF, 8'h00, 1'b0);
        send_byte(8'h00, 8'hFF, 1'b0);
        send_byte(8'hA5, 8'h00, 1'b0);
        send_byte(8'hFF ^ 8'hA5, 8'h00, 1'b1);
    endtask

    task automatic test_verify();
        program_reg(tblv_pkg::REG_LOAD_MODE, 32'd0);
        send_block(BLK_GOOD);
        send_block(BLK_VERIFY_ERR);
    endtask

    task automatic test_flag_errors();
        program_reg(tblv_pkg::REG_EXPECTED_FLAG, 32'h00);
        send_byte(8'hFF, 8'h00, 1'b1);
        send_byte(8'h80, 8'h00, 1'b0);
        send_byte(8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_short_blocks();
        send_byte(cfg_flag, 8'h00, 1'b1);
        send_byte(cfg_flag, 8'h00, 1'b0);
        send_byte(8'h3C, 8'h3C, 1'b1);
    endtask

    task automatic test_checksum();
        program_reg(tblv_pkg::REG_LOAD_MODE, 32'd1);
        send_block(BLK_BAD_SUM);
        send_block(BLK_TRAILING);
    endtask

    task automatic test_max_count();
        program_reg(tblv_pkg::REG_BYTE_COUNT, 32'hFFFF);
        program_reg(tblv_pkg::REG_START_ADDRESS, 32'h0000);
        send_block(BLK_BAD_FLAG);
        send_byte(cfg_flag, 8'h00, 1'b0);
        send_byte(8'h5A, 8'h00, 1'b1);
    endtask

    task automatic test_random_blocks(input int n_items);
        int stop_at;
        int pick;
        stop_at = n_bytes_sent + n_items;
        while (n_bytes_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                shuffle_config();
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_tail($urandom_range(1, 6));
            end else if (pick < 55) begin
                send_block(BLK_GOOD);
            end else if (pick < 63) begin
                send_block(BLK_BAD_FLAG);
            end else if (pick < 73) begin
                send_block(BLK_VERIFY_ERR);
            end else if (pick < 83) begin
                send_block(BLK_SHORT);
            end else if (pick < 91) begin
                send_block(BLK_BAD_SUM);
            end else begin
                send_block(BLK_TRAILING);
            end
        end
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        test_random_blocks(90);
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_length();
        test_load_wrap();
        test_verify();
        test_flag_errors();
        test_short_blocks();
        test_checksum();
        test_max_count();
        test_random_blocks(130);
        test_back_to_back();
        test_random_blocks(130);
        drain_results();
        repeat (6) @(posedge i_clk);
        n_errors += pending_results.size();
        if (n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
